### rtl/rcc_pkg.sv
package rcc_pkg;

	localparam int KERNEL_SIZE    = 3;
	localparam int COEF_FRAC_BITS = 8;
	localparam int COEF_W         = 16;
	localparam int ROW_W          = 48;
	localparam int DIM_W          = 11;
	localparam int IDX_W          = 8;
	localparam int PROD_W         = 25;
	localparam int SUM_W          = 28;
	localparam int QDEPTH         = 4;
	localparam int QAW            = $clog2(QDEPTH);

	// register indexes on the configuration channel
	localparam logic [IDX_W-1:0] REG_COEF_TOP = 8'd0;
	localparam logic [IDX_W-1:0] REG_COEF_MID = 8'd1;
	localparam logic [IDX_W-1:0] REG_COEF_BOT = 8'd2;
	localparam logic [IDX_W-1:0] REG_WIDTH    = 8'd3;
	localparam logic [IDX_W-1:0] REG_HEIGHT   = 8'd4;

	// reset kernel: 4-neighbour sharpen, taps in Q7.8
	localparam logic [ROW_W-1:0] COEF_EDGE_RST = 48'h0000_FFC0_0000;
	localparam logic [ROW_W-1:0] COEF_MID_RST  = 48'hFFC0_0200_FFC0;
	localparam logic [DIM_W-1:0] DIM_RST       = 11'd1024;

	// [0] red, [1] green, [2] blue
	typedef logic [2:0][7:0] pix_t;

	// [row][column], column 2 is the newest
	typedef pix_t [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] win_t;

	typedef struct packed {
		pix_t upper;
		pix_t lower;
	} line_t;

	typedef struct packed {
		logic v;
		logic emit_a;
		logic emit_b;
		logic lval_a;
		logic lval_b;
		logic eof;
	} emit_t;

	typedef struct packed {
		pix_t rgb;
		logic last;
		logic eof;
	} res_t;

	function automatic logic signed [COEF_W-1:0] tap(input logic [ROW_W-1:0] row,
		input int j);
		return signed'(row[COEF_W*j +: COEF_W]);
	endfunction

	// truncate toward zero, clamp to 0..255
	function automatic logic [7:0] saturate(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-1:0] q;
		q = unsigned'(s) >> COEF_FRAC_BITS;
		if (s <= 0) begin
			return 8'd0;
		end
		if (q > SUM_W'(255)) begin
			return 8'hFF;
		end
		return q[7:0];
	endfunction

endpackage

### rtl/rcc_ifs.sv
interface rcc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic       is_padding;

	modport source (output valid, in_red, in_green, in_blue, is_padding, input ready);
	modport sink (input valid, in_red, in_green, in_blue, is_padding, output ready);
endinterface

interface rcc_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       last_of_run;
	logic       end_of_frame;

	modport source (output valid, out_red, out_green, out_blue, last_of_run, end_of_frame,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, last_of_run, end_of_frame,
		output ready);
endinterface

interface rcc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [rcc_pkg::IDX_W-1:0]   index;
	logic [rcc_pkg::ROW_W-1:0]   wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

### rtl/rcc_ram.sv
module rcc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/rcc_mac.sv
module rcc_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  rcc_pkg::win_t               win,
	input  rcc_pkg::emit_t              emit,
	input  logic [rcc_pkg::ROW_W-1:0]   coef_top,
	input  logic [rcc_pkg::ROW_W-1:0]   coef_mid,
	input  logic [rcc_pkg::ROW_W-1:0]   coef_bot,
	output rcc_pkg::res_t               res_a,
	output rcc_pkg::res_t               res_b,
	output logic                        vld_a,
	output logic                        vld_b
);

	localparam int KS = rcc_pkg::KERNEL_SIZE;

	logic [KS-1:0][rcc_pkg::ROW_W-1:0] coef;
	rcc_pkg::win_t  win_a;
	rcc_pkg::win_t  win_b;
	rcc_pkg::emit_t emit_s3;
	rcc_pkg::emit_t emit_s4;

	logic signed [rcc_pkg::PROD_W-1:0] prod_a_s3 [3][KS][KS];
	logic signed [rcc_pkg::PROD_W-1:0] prod_b_s3 [3][KS][KS-1];
	logic signed [rcc_pkg::SUM_W-1:0]  rsum_a_s4 [3][KS];
	logic signed [rcc_pkg::SUM_W-1:0]  rsum_b_s4 [3][KS];
	logic signed [rcc_pkg::SUM_W-1:0]  tot_a [3];
	logic signed [rcc_pkg::SUM_W-1:0]  tot_b [3];

	assign coef = {coef_bot, coef_mid, coef_top};

	// lane a: full window; lane b: right-edge result, columns 1..2 on taps 0..1
	always_comb begin
		win_a = win;
		win_b = win;
		for (int i = 0; i < KS; i++) begin
			if (!emit.lval_a) begin
				win_a[i][0] = '0;
			end
			if (!emit.lval_b) begin
				win_b[i][1] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s3 <= '0;
			emit_s4 <= '0;
		end else if (en) begin
			emit_s3 <= emit;
			emit_s4 <= emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int i = 0; i < KS; i++) begin
					for (int j = 0; j < KS; j++) begin
						prod_a_s3[ch][i][j] <= $signed({1'b0, win_a[i][j][ch]}) *
							rcc_pkg::tap(coef[i], j);
					end
					for (int j = 0; j < KS - 1; j++) begin
						prod_b_s3[ch][i][j] <= $signed({1'b0, win_b[i][j+1][ch]}) *
							rcc_pkg::tap(coef[i], j);
					end
					rsum_a_s4[ch][i] <= rcc_pkg::SUM_W'(prod_a_s3[ch][i][0]) +
						rcc_pkg::SUM_W'(prod_a_s3[ch][i][1]) +
						rcc_pkg::SUM_W'(prod_a_s3[ch][i][2]);
					rsum_b_s4[ch][i] <= rcc_pkg::SUM_W'(prod_b_s3[ch][i][0]) +
						rcc_pkg::SUM_W'(prod_b_s3[ch][i][1]);
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			tot_a[ch] = rsum_a_s4[ch][0] + rsum_a_s4[ch][1] + rsum_a_s4[ch][2];
			tot_b[ch] = rsum_b_s4[ch][0] + rsum_b_s4[ch][1] + rsum_b_s4[ch][2];
			res_a.rgb[ch] = rcc_pkg::saturate(tot_a[ch]);
			res_b.rgb[ch] = rcc_pkg::saturate(tot_b[ch]);
		end
		res_a.last = !emit_s4.emit_b;
		res_a.eof  = 1'b0;
		res_b.last = 1'b1;
		res_b.eof  = emit_s4.eof;
	end

	assign vld_a = emit_s4.v && emit_s4.emit_a;
	assign vld_b = emit_s4.v && emit_s4.emit_b;

endmodule

### rtl/rgb_3x3_convolution_core.sv
// RGB 3x3 convolution, zero padded, one kernel shared by all three channels.
//
// pix: pixels in raster order, one transfer per pixel. After the image the source
//   sends one extra row (the flush row); its pixels count as zero, as does any
//   pixel with is_padding set.
// res: filtered pixels in raster order. The result for pixel (r, c) follows the
//   transfer of pixel (r+1, c+1); the last pixel of a row also yields the
//   right-edge result of the row above, so it gives two results. last_of_run
//   marks the final result of one input transfer, end_of_frame the bottom-right
//   pixel of the image.
// cfg: register writes (kernel rows, width, height), always ready; write only
//   while the block is idle.
// Throughput: one pixel per clock. Results pass the line-memory, window,
//   product and row-sum registers into a four-entry queue that drains one per
//   clock; pix.ready drops while the queue holds more than two entries, so a
//   stalled receiver halts the whole pipeline without loss. The line memory
//   (one read, one write per pixel) sets the one-pixel-per-clock figure.
// Reset: counters at row 0, column 0, window cleared, queue empty, default
//   sharpen kernel and 1024x1024 geometry. The line memory is not cleared.
module rgb_3x3_convolution_core #(
	parameter int MAX_WIDTH = 1024
) (
	input logic      clk,
	input logic      arst_n,
	rcc_pix_if.sink  pix,
	rcc_res_if.source res,
	rcc_cfg_if.sink  cfg
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = CW + 1;
	localparam int XW    = (WW > rcc_pkg::DIM_W) ? WW : rcc_pkg::DIM_W;
	localparam int DIM_W = rcc_pkg::DIM_W;
	localparam int QAW   = rcc_pkg::QAW;
	localparam int KS    = rcc_pkg::KERNEL_SIZE;

	// ---------------------------------------------------------------- registers
	logic [rcc_pkg::ROW_W-1:0] coef_top_q;
	logic [rcc_pkg::ROW_W-1:0] coef_mid_q;
	logic [rcc_pkg::ROW_W-1:0] coef_bot_q;
	logic [DIM_W-1:0]          width_q;
	logic [DIM_W-1:0]          height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= rcc_pkg::COEF_EDGE_RST;
			coef_mid_q <= rcc_pkg::COEF_MID_RST;
			coef_bot_q <= rcc_pkg::COEF_EDGE_RST;
			width_q    <= rcc_pkg::DIM_RST;
			height_q   <= rcc_pkg::DIM_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rcc_pkg::REG_COEF_TOP: coef_top_q <= cfg.wdata;
				rcc_pkg::REG_COEF_MID: coef_mid_q <= cfg.wdata;
				rcc_pkg::REG_COEF_BOT: coef_bot_q <= cfg.wdata;
				rcc_pkg::REG_WIDTH:    width_q    <= cfg.wdata[DIM_W-1:0];
				rcc_pkg::REG_HEIGHT:   height_q   <= cfg.wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry: width clamped to 1..MAX_WIDTH, height at least 1
	logic [XW-1:0]    w_ext;
	logic [WW-1:0]    w_eff;
	logic [DIM_W-1:0] h_eff;

	always_comb begin
		w_ext = XW'(width_q);
		if (w_ext == '0) begin
			w_ext = XW'(1);
		end else if (w_ext > XW'(MAX_WIDTH)) begin
			w_ext = XW'(MAX_WIDTH);
		end
		w_eff = WW'(w_ext);
		h_eff = (height_q == '0) ? DIM_W'(1) : height_q;
	end

	// ---------------------------------------------------------------- flow control
	// whole pipeline moves together; it stops only when the queue may not take
	// a pair of results
	logic [QAW:0] q_count_q;
	logic         adv;
	logic         acc;

	assign adv       = q_count_q <= (QAW+1)'(rcc_pkg::QDEPTH - 2);
	assign pix.ready = adv;
	assign acc       = pix.valid && adv;

	// ---------------------------------------------------------------- position
	logic [CW-1:0]    col_q;
	logic [DIM_W-1:0] row_q;
	logic             col_wrap;
	logic [CW-1:0]    c_pre;
	logic [DIM_W:0]   r_tmp;
	logic [DIM_W-1:0] r_pre;
	logic [WW-1:0]    c_inc;
	logic             row_end;
	rcc_pkg::pix_t    cur;
	rcc_pkg::emit_t   emit_d;

	// a geometry change can leave the counters outside the frame: realign first
	always_comb begin
		col_wrap = {1'b0, col_q} >= w_eff;
		c_pre    = col_wrap ? '0 : col_q;
		r_tmp    = {1'b0, row_q} + {{DIM_W{1'b0}}, col_wrap};
		r_pre    = (r_tmp > {1'b0, h_eff}) ? '0 : r_tmp[DIM_W-1:0];
		c_inc    = {1'b0, c_pre} + WW'(1);
		row_end  = c_inc >= w_eff;

		if (pix.is_padding || r_pre >= h_eff) begin
			cur = '0;
		end else begin
			cur = {pix.in_blue, pix.in_green, pix.in_red};
		end

		emit_d.v      = acc;
		emit_d.emit_a = (r_pre != '0) && (c_pre != '0);
		emit_d.emit_b = (r_pre != '0) && row_end;
		emit_d.lval_a = c_pre >= CW'(2);
		emit_d.lval_b = c_pre != '0;
		emit_d.eof    = r_pre == h_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= (r_pre >= h_eff) ? '0 : r_pre + DIM_W'(1);
			end else begin
				col_q <= c_inc[CW-1:0];
				row_q <= r_pre;
			end
		end
	end

	// ---------------------------------------------------------------- line memory
	// entry c holds the two rows above the current one at column c:
	// read on acceptance, written back from stage s1 as the pipeline advances, with the row shifted up
	rcc_pkg::emit_t emit_s1;
	logic [CW-1:0]  c_s1;
	rcc_pkg::pix_t  cur_s1;
	logic           top_en_s1;
	logic           mid_en_s1;
	logic           fwd_s1;
	rcc_pkg::line_t wr_q;
	rcc_pkg::line_t ram_line;
	rcc_pkg::line_t line_rd;
	rcc_pkg::line_t line_wr;
	logic [$bits(rcc_pkg::line_t)-1:0] ram_rdata;
	logic           ram_we;
	rcc_pkg::pix_t  top_px;
	rcc_pkg::pix_t  mid_px;

	assign ram_we   = adv && emit_s1.v;
	assign ram_line = rcc_pkg::line_t'(ram_rdata);
	// back-to-back hit on one column (width of one): memory read missed the write
	assign line_rd  = fwd_s1 ? wr_q : ram_line;
	assign top_px   = top_en_s1 ? line_rd.upper : '0;
	assign mid_px   = mid_en_s1 ? line_rd.lower : '0;
	assign line_wr  = '{upper: line_rd.lower, lower: cur_s1};

	rcc_ram #(
		.WIDTH ($bits(rcc_pkg::line_t)),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (c_s1),
		.wdata (line_wr),
		.re    (acc),
		.raddr (c_pre),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= '0;
			fwd_s1  <= 1'b0;
		end else if (adv) begin
			emit_s1 <= emit_d;
			fwd_s1  <= acc && emit_s1.v && (c_s1 == c_pre);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			c_s1      <= c_pre;
			cur_s1    <= cur;
			top_en_s1 <= r_pre >= DIM_W'(2);
			mid_en_s1 <= r_pre != '0;
		end
		if (ram_we) begin
			wr_q <= line_wr;
		end
	end

	// ---------------------------------------------------------------- window
	rcc_pkg::win_t  win_q;
	rcc_pkg::emit_t emit_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			emit_s2 <= '0;
		end else if (adv) begin
			emit_s2 <= emit_s1;
			if (emit_s1.v) begin
				for (int i = 0; i < KS; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= top_px;
				win_q[1][2] <= mid_px;
				win_q[2][2] <= cur_s1;
			end
		end
	end

	// ---------------------------------------------------------------- arithmetic
	rcc_pkg::res_t res_a;
	rcc_pkg::res_t res_b;
	logic          vld_a;
	logic          vld_b;

	rcc_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.win      (win_q),
		.emit     (emit_s2),
		.coef_top (coef_top_q),
		.coef_mid (coef_mid_q),
		.coef_bot (coef_bot_q),
		.res_a    (res_a),
		.res_b    (res_b),
		.vld_a    (vld_a),
		.vld_b    (vld_b)
	);

	// ---------------------------------------------------------------- result queue
	rcc_pkg::res_t q_mem_q [rcc_pkg::QDEPTH];
	logic [QAW-1:0] q_wptr_q;
	logic [QAW-1:0] q_rptr_q;
	logic           wr_a;
	logic           wr_b;
	logic [1:0]     n_wr;
	logic           rd;
	rcc_pkg::res_t  first;

	assign wr_a  = adv && vld_a;
	assign wr_b  = adv && vld_b;
	assign n_wr  = {wr_a && wr_b, wr_a ^ wr_b};
	assign rd    = res.valid && res.ready;
	assign first = wr_a ? res_a : res_b;

	always_ff @(posedge clk) begin
		if (wr_a || wr_b) begin
			q_mem_q[q_wptr_q] <= first;
		end
		if (wr_a && wr_b) begin
			q_mem_q[q_wptr_q + QAW'(1)] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wptr_q  <= '0;
			q_rptr_q  <= '0;
			q_count_q <= '0;
		end else begin
			q_wptr_q  <= q_wptr_q + QAW'(n_wr);
			q_rptr_q  <= q_rptr_q + QAW'(rd);
			q_count_q <= q_count_q + (QAW+1)'(n_wr) - (QAW+1)'(rd);
		end
	end

	assign res.valid        = q_count_q != '0;
	assign res.out_red      = q_mem_q[q_rptr_q].rgb[0];
	assign res.out_green    = q_mem_q[q_rptr_q].rgb[1];
	assign res.out_blue     = q_mem_q[q_rptr_q].rgb[2];
	assign res.last_of_run  = q_mem_q[q_rptr_q].last;
	assign res.end_of_frame = q_mem_q[q_rptr_q].eof;

	// ---------------------------------------------------------------- checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count_q <= (QAW+1)'(rcc_pkg::QDEPTH))
		else $error("result queue overflow");

	a_fwd_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$past(acc) && fwd_s1 |-> $past(ram_we) && ($past(c_s1) == c_s1))
		else $error("line forward without a write to the same column");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.end_of_frame |-> res.last_of_run)
		else $error("frame end not on the last result of a transfer");

endmodule
